// ===== hw/rtl/lcab_pkg.sv =====
// Shared types, constants and helpers for the LCA binary lifting engine.
`timescale 1ns / 1ps
`default_nettype none
package lcab_pkg;

	localparam int MAX_NODES   = 16384;
	localparam int LIFT_LEVELS = 14;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int DEPTH_W     = 14;
	localparam int CNT_W       = 15;
	localparam int FIELD_W     = 14;
	localparam int JT_W        = NODE_W + 1;
	localparam int JT_AW       = LVL_W + NODE_W;
	localparam int JT_DEPTH    = 1 << JT_AW;
	localparam int SUM_W       = (1 << LVL_W) + DEPTH_W + 1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [NODE_W-1:0]  node;
		logic [NODE_W-1:0]  parent;
		logic               has_parent;
		logic [DEPTH_W-1:0] depth;
		logic [NODE_W-1:0]  other;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_REPLY,
		ST_BCHK, ST_BRD0, ST_BRD1, ST_BWR,
		ST_QDB, ST_QSW, ST_QTOP, ST_RCHK, ST_RJ, ST_RD,
		ST_CMP, ST_LA, ST_LB, ST_LC, ST_P0, ST_P1, ST_FD
	} st_t;

	// highest set bit of a depth, capped at the top lifting level
	function automatic logic [LVL_W-1:0] top_level(input logic [DEPTH_W-1:0] d);
		int t;
		t = 0;
		for (int k = 1; k < DEPTH_W; k++) begin
			if (d[k]) t = k;
		end
		if (t > LIFT_LEVELS - 1) t = LIFT_LEVELS - 1;
		return LVL_W'(t);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lcab_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lcab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hw/rtl/lcab_front.sv =====
// Input stage: takes items, unpacks and classifies them, drops unused commands.
`timescale 1ns / 1ps
`default_nettype none
module lcab_front import lcab_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	output logic             push,
	output item_t            push_item,
	input  wire logic        full
);
	item_t item_s1;
	logic  v_s1;
	logic  cmd_ok;

	assign s_axis_tready = !v_s1 || !full;
	assign cmd_ok = (item_s1.cmd == CMD_LOAD) || (item_s1.cmd == CMD_BUILD) ||
		(item_s1.cmd == CMD_QUERY);
	assign push = v_s1 && !full && cmd_ok;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			v_s1 <= 1'b1;
		end else if (!full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd        <= cmd_t'(s_axis_tuser);
			item_s1.node       <= NODE_W'(s_axis_tdata[13:0]);
			item_s1.parent     <= NODE_W'(s_axis_tdata[27:14]);
			item_s1.has_parent <= s_axis_tdata[28];
			item_s1.depth      <= s_axis_tdata[42:29];
			item_s1.other      <= NODE_W'(s_axis_tdata[56:43]);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lcab_queue.sv =====
// Two-entry item queue between the front and the execution engine.
`timescale 1ns / 1ps
`default_nettype none
module lcab_queue import lcab_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      head
);
	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lcab_back.sv =====
// Execution engine: node loads, jump table build and LCA queries over the two RAMs.
`timescale 1ns / 1ps
`default_nettype none
module lcab_back import lcab_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] node_count,
	input  wire logic             q_valid,
	input  item_t                 q_item,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [31:0]           m_axis_tdata,
	output logic [1:0]            m_axis_tuser
);
	st_t st_q, st_d;
	logic [NODE_W-1:0]  a_q, a_d, b_q, b_d, i_q, i_d, rn_q, rn_d;
	logic [DEPTH_W-1:0] da_q, da_d, db_q, db_d, rdp_q, rdp_d;
	logic [LVL_W-1:0]   lv_q, lv_d, top_q, top_d;
	logic [LVL_W:0]     j_q, j_d;
	logic [JT_W-1:0]    ea_q, ea_d;
	cmd_t               kind_q, kind_d;
	logic               ov_q, ov_d;
	logic [FIELD_W-1:0] on_q, on_d, od_q, od_d;
	cmd_t               ok_q, ok_d;

	logic               dwe, jwe;
	logic [NODE_W-1:0]  dwa, dra;
	logic [DEPTH_W-1:0] dwd, d_rd;
	logic [JT_AW-1:0]   jwa, jra;
	logic [JT_W-1:0]    jwd, j_rd;
	logic [NODE_W:0]    n;
	logic [LVL_W-1:0]   jm1;
	logic [JT_W-1:0]    none_e;

	assign none_e = {1'b1, {NODE_W{1'b0}}};
	assign n = (32'(node_count) > MAX_NODES) ? (NODE_W+1)'(MAX_NODES) : (NODE_W+1)'(node_count);
	assign jm1 = LVL_W'(j_q - 1'b1);

	lcab_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth (
		.clk(clk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(d_rd)
	);

	lcab_ram #(.WIDTH(JT_W), .DEPTH(JT_DEPTH)) u_jump (
		.clk(clk), .we(jwe), .waddr(jwa), .wdata(jwd), .raddr(jra), .rdata(j_rd)
	);

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {4'd0, od_q, on_q};
	assign m_axis_tuser  = ok_q;

	always_comb begin
		st_d = st_q; a_d = a_q; b_d = b_q; i_d = i_q; rn_d = rn_q;
		da_d = da_q; db_d = db_q; rdp_d = rdp_q; lv_d = lv_q; top_d = top_q;
		j_d = j_q; ea_d = ea_q; kind_d = kind_q;
		ov_d = ov_q; on_d = on_q; od_d = od_q; ok_d = ok_q;
		pop = 1'b0;
		dwe = 1'b0; dwa = q_item.node; dwd = q_item.depth; dra = a_q;
		jwe = 1'b0; jwa = {jm1, i_q}; jwd = j_rd; jra = {lv_q, a_q};
		if (ov_q && m_axis_tready) ov_d = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					kind_d = q_item.cmd;
					a_d = q_item.node;
					b_d = q_item.other;
					rn_d = '0;
					rdp_d = '0;
					case (q_item.cmd)
						CMD_LOAD: begin
							dwe = 1'b1;
							jwe = 1'b1;
							jwa = {LVL_W'(0), q_item.node};
							jwd = q_item.has_parent ? {1'b0, q_item.parent} : none_e;
							st_d = ST_REPLY;
						end
						CMD_BUILD: begin
							j_d = (LVL_W+1)'(1);
							st_d = ST_BCHK;
						end
						CMD_QUERY: begin
							dra = q_item.node;
							st_d = ST_QDB;
						end
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_REPLY: begin
				if (!ov_q || m_axis_tready) begin
					ov_d = 1'b1;
					ok_d = kind_q;
					on_d = FIELD_W'(rn_q);
					od_d = FIELD_W'(rdp_q);
					st_d = ST_IDLE;
				end
			end
			ST_BCHK: begin
				if (32'(j_q) < LIFT_LEVELS && (SUM_W'(1) << j_q) < SUM_W'(n)) begin
					i_d = '0;
					st_d = ST_BRD0;
				end else begin
					st_d = ST_REPLY;
				end
			end
			ST_BRD0: begin
				jra = {jm1, i_q};
				st_d = ST_BRD1;
			end
			ST_BRD1, ST_BWR: begin
				if (st_q == ST_BRD1 && !j_rd[JT_W-1]) begin
					jra = {jm1, j_rd[NODE_W-1:0]};
					st_d = ST_BWR;
				end else begin
					jwe = 1'b1;
					jwa = {j_q[LVL_W-1:0], i_q};
					jwd = (st_q == ST_BRD1) ? none_e : j_rd;
					if ((NODE_W+1)'(i_q) + 1'b1 == n) begin
						j_d = j_q + 1'b1;
						st_d = ST_BCHK;
					end else begin
						i_d = i_q + 1'b1;
						st_d = ST_BRD0;
					end
				end
			end
			ST_QDB: begin
				da_d = d_rd;
				dra = b_q;
				st_d = ST_QSW;
			end
			ST_QSW: begin
				if (da_q < d_rd) begin
					a_d = b_q; b_d = a_q; da_d = d_rd; db_d = da_q;
				end else begin
					db_d = d_rd;
				end
				st_d = ST_QTOP;
			end
			ST_QTOP: begin
				top_d = top_level(da_q);
				lv_d = top_level(da_q);
				st_d = ST_RCHK;
			end
			ST_RCHK, ST_RJ, ST_RD: begin
				if (st_q == ST_RCHK &&
						SUM_W'(da_q) >= SUM_W'(db_q) + (SUM_W'(1) << lv_q)) begin
					jra = {lv_q, a_q};
					st_d = ST_RJ;
				end else if (st_q == ST_RJ && !j_rd[JT_W-1]) begin
					a_d = j_rd[NODE_W-1:0];
					dra = j_rd[NODE_W-1:0];
					st_d = ST_RD;
				end else begin
					if (st_q == ST_RD) da_d = d_rd;
					if (lv_q == '0) begin
						st_d = ST_CMP;
					end else begin
						lv_d = lv_q - 1'b1;
						st_d = ST_RCHK;
					end
				end
			end
			ST_CMP: begin
				if (a_q == b_q) begin
					dra = a_q;
					st_d = ST_FD;
				end else begin
					lv_d = top_q;
					st_d = ST_LA;
				end
			end
			ST_LA: begin
				jra = {lv_q, a_q};
				st_d = ST_LB;
			end
			ST_LB: begin
				ea_d = j_rd;
				jra = {lv_q, b_q};
				st_d = ST_LC;
			end
			ST_LC: begin
				if (!ea_q[JT_W-1] && !j_rd[JT_W-1] && ea_q != j_rd) begin
					a_d = ea_q[NODE_W-1:0];
					b_d = j_rd[NODE_W-1:0];
				end
				if (lv_q == '0) begin
					st_d = ST_P0;
				end else begin
					lv_d = lv_q - 1'b1;
					st_d = ST_LA;
				end
			end
			ST_P0: begin
				jra = {LVL_W'(0), a_q};
				st_d = ST_P1;
			end
			ST_P1: begin
				if (!j_rd[JT_W-1]) begin
					a_d = j_rd[NODE_W-1:0];
					dra = j_rd[NODE_W-1:0];
				end else begin
					dra = a_q;
				end
				st_d = ST_FD;
			end
			ST_FD: begin
				rn_d = a_q;
				rdp_d = d_rd;
				st_d = ST_REPLY;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d; b_q <= b_d; i_q <= i_d; rn_q <= rn_d;
		da_q <= da_d; db_q <= db_d; rdp_q <= rdp_d;
		lv_q <= lv_d; top_q <= top_d; j_q <= j_d; ea_q <= ea_d; kind_q <= kind_d;
		on_q <= on_d; od_q <= od_d; ok_q <= ok_d;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lca_binary_lifting.sv =====
// Top level of the lowest common ancestor engine.
// Load items (tuser 0) store a node's parent and depth. A build item (tuser 1)
// fills each level j >= 1 with 2^j below node_count from level j-1. For each node
// and level it reads the lower entry and, unless that entry is none, the entry it
// points to, then writes the new entry; each level starts with a check state. A
// build is limited by the single read port of the jump table RAM. A query (tuser 2)
// reads both depths, makes the deeper node the one to raise, and raises it level
// by level. When the raised nodes still differ, it lifts both from the top level
// down and takes the parent; it then reads the depth of the result. One item
// executes at a time; a two-entry queue and an output register let input and
// output stall independently. Every accepted load, build or query gives exactly
// one reply; tuser 3 is dropped. The tables are not cleared after reset, so
// queries and builds only make sense over loaded nodes. node_count (reset 1) must
// be written only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module lca_binary_lifting import lcab_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// node[13:0], parent_node[27:14], has_parent[28], node_depth[42:29], other_node[56:43]
	input  wire logic [63:0] s_axis_tdata,
	// cmd[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// common_node[13:0], common_depth[27:14]
	output logic [31:0]      m_axis_tdata,
	// reply_kind[1:0]
	output logic [1:0]       m_axis_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data
);
	logic [CNT_W-1:0] nc_q;
	logic             push, full, pop, not_empty;
	item_t            push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nc_q <= CNT_W'(1);
		else if (cfg_valid) nc_q <= cfg_data;
	end

	lcab_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.push(push), .push_item(push_item), .full(full)
	);

	lcab_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	lcab_back u_back (
		.clk(clk), .arst_n(arst_n), .node_count(nc_q),
		.q_valid(not_empty), .q_item(head), .pop(pop),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/lcab_checker.sv =====
// Port-level checks for the LCA engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lcab_checker import lcab_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("reply changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == CMD_LOAD || m_axis_tuser == CMD_BUILD ||
		m_axis_tuser == CMD_QUERY)
		else $error("unused reply kind");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != CMD_QUERY |-> m_axis_tdata == 32'd0)
		else $error("load or build reply carries data");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
		else $error("padding bits set");
endmodule

bind lca_binary_lifting lcab_checker u_lcab_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
